### rtl/ita_pkg.sv
// Package: shared constants, types and the digit table of the integer to ASCII converter.
`default_nettype none
package ita_pkg;

  localparam int MAX_CHARS = 33;
  localparam int VALUE_W   = 32;
  localparam int RADIX_W   = 5;
  localparam int DIGIT_W   = 4;
  localparam int CHAR_W    = 7;
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);
  localparam int ADDR_W    = $clog2(MAX_CHARS);
  localparam int STEP_W    = $clog2(VALUE_W);

  localparam logic [RADIX_W-1:0] RADIX_MIN  = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX  = RADIX_W'(16);
  localparam logic [CHAR_W-1:0]  MINUS_CHAR = 7'h2d;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_FIN,
    ST_SIGN,
    ST_RD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [VALUE_W-1:0]   dividend;
    logic [RADIX_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [VALUE_W-1:0]   quotient;
    logic [DIGIT_W-1:0]   remainder;
  } div_rsp_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    unique case (d)
      4'd0:  c = 7'h30;
      4'd1:  c = 7'h31;
      4'd2:  c = 7'h32;
      4'd3:  c = 7'h33;
      4'd4:  c = 7'h34;
      4'd5:  c = 7'h35;
      4'd6:  c = 7'h36;
      4'd7:  c = 7'h37;
      4'd8:  c = 7'h38;
      4'd9:  c = 7'h39;
      4'd10: c = 7'h61;
      4'd11: c = 7'h62;
      4'd12: c = 7'h63;
      4'd13: c = 7'h64;
      4'd14: c = 7'h65;
      default: c = 7'h66;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/ita_in_if.sv
// Interface: input request channel carrying value, radix and signed mode.
`default_nettype none
interface ita_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ita_pkg::VALUE_W-1:0]  value;
  logic [ita_pkg::RADIX_W-1:0]         radix;
  logic                                signed_mode;

  modport source (output valid, output value, output radix, output signed_mode,
                  input ready);
  modport sink   (input valid, input value, input radix, input signed_mode,
                  output ready);
endinterface
`default_nettype wire

### rtl/ita_out_if.sv
// Interface: output request channel carrying one character and its last mark.
`default_nettype none
interface ita_out_if;
  logic                        valid;
  logic                        ready;
  logic [ita_pkg::CHAR_W-1:0]  character;
  logic                        last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

### rtl/ita_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module ita_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/ita_div.sv
// Restoring divider: 32-bit dividend by a radix, one quotient bit per cycle.
`default_nettype none
module ita_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ita_pkg::div_req_t req,
  output ita_pkg::div_rsp_t      rsp
);

  logic                           busy;
  logic [ita_pkg::STEP_W-1:0]     step;
  logic [ita_pkg::VALUE_W-1:0]    quo;
  logic [ita_pkg::DIGIT_W-1:0]    rem;
  logic [ita_pkg::RADIX_W-1:0]    divisor;
  logic                           done;
  logic [ita_pkg::RADIX_W-1:0]    trial;
  logic                           fits;
  logic [ita_pkg::RADIX_W-1:0]    diff;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    trial = {rem, quo[ita_pkg::VALUE_W-1]};
    fits  = trial >= divisor;
    diff  = trial - divisor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == ita_pkg::STEP_W'(ita_pkg::VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      quo <= {quo[ita_pkg::VALUE_W-2:0], fits};
      rem <= fits ? diff[ita_pkg::DIGIT_W-1:0] : trial[ita_pkg::DIGIT_W-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule
`default_nettype wire

### rtl/integer_to_ascii_radix.sv
// Top level: converts a 32-bit integer to ASCII characters in a radix from 2 to 16.
`default_nettype none
// Takes one request (value, radix, signed_mode) and returns its ASCII text one
// character per output request, most significant first, lower-case hex letters,
// with last set on the final character. A radix below 2 is taken as 2 and one
// above 16 as 16. With signed_mode set and bit 31 set, a minus sign leads and
// the magnitude follows; the most negative value prints as -2147483648. Zero
// prints as a single '0'. Digits come from a bit-serial restoring divider
// and are kept in a small digit RAM; each digit is read back from the RAM
// and presented the next cycle. The block takes no new request until the
// last character of the current one has been taken. Only the MAX_CHARS
// least significant characters are kept if MAX_CHARS is below 33.
module integer_to_ascii_radix (
  input  wire logic  clk,
  input  wire logic  rst,
  ita_in_if.sink     din,
  ita_out_if.source  dout
);

  ita_pkg::state_t                state;
  ita_pkg::state_t                state_next;
  logic [ita_pkg::VALUE_W-1:0]    mag;
  logic [ita_pkg::RADIX_W-1:0]    base;
  logic                           neg;
  logic [ita_pkg::CNT_W-1:0]      count;
  logic [ita_pkg::ADDR_W-1:0]     ptr;

  ita_pkg::div_req_t              div_req;
  ita_pkg::div_rsp_t              div_rsp;

  logic                           ram_wr_en;
  logic                           ram_rd_en;
  logic [ita_pkg::DIGIT_W-1:0]    ram_rd_data;

  logic                           in_acc;
  logic                           out_acc;
  logic                           room;
  logic [ita_pkg::RADIX_W-1:0]    base_in;

  assign in_acc  = din.valid && din.ready;
  assign out_acc = dout.valid && dout.ready;
  assign room    = count < ita_pkg::CNT_W'(ita_pkg::MAX_CHARS);

  // Clamp the radix to the supported range.
  always_comb begin
    priority if (din.radix < ita_pkg::RADIX_MIN) begin
      base_in = ita_pkg::RADIX_MIN;
    end else if (din.radix > ita_pkg::RADIX_MAX) begin
      base_in = ita_pkg::RADIX_MAX;
    end else begin
      base_in = din.radix;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ita_pkg::ST_IDLE: begin
        if (in_acc) state_next = ita_pkg::ST_START;
      end
      ita_pkg::ST_START: begin
        state_next = ita_pkg::ST_WAIT;
      end
      ita_pkg::ST_WAIT: begin
        if (div_rsp.done) begin
          state_next = (div_rsp.quotient == '0) ? ita_pkg::ST_FIN : ita_pkg::ST_START;
        end
      end
      ita_pkg::ST_FIN: begin
        state_next = (neg && room) ? ita_pkg::ST_SIGN : ita_pkg::ST_RD;
      end
      ita_pkg::ST_SIGN: begin
        if (out_acc) state_next = ita_pkg::ST_RD;
      end
      ita_pkg::ST_RD: begin
        state_next = ita_pkg::ST_OUT;
      end
      ita_pkg::ST_OUT: begin
        if (out_acc) begin
          state_next = (ptr == '0) ? ita_pkg::ST_IDLE : ita_pkg::ST_RD;
        end
      end
      default: begin
        state_next = ita_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    din.ready        = 1'b0;
    dout.valid       = 1'b0;
    dout.character   = ita_pkg::digit_char(ram_rd_data);
    dout.last        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = mag;
    div_req.divisor  = base;
    ram_wr_en        = 1'b0;
    ram_rd_en        = 1'b0;
    unique case (state)
      ita_pkg::ST_IDLE: begin
        din.ready = 1'b1;
      end
      ita_pkg::ST_START: begin
        div_req.start = 1'b1;
      end
      ita_pkg::ST_WAIT: begin
        ram_wr_en = div_rsp.done && room;
      end
      ita_pkg::ST_FIN: begin
      end
      ita_pkg::ST_SIGN: begin
        dout.valid     = 1'b1;
        dout.character = ita_pkg::MINUS_CHAR;
      end
      ita_pkg::ST_RD: begin
        ram_rd_en = 1'b1;
      end
      ita_pkg::ST_OUT: begin
        dout.valid = 1'b1;
        dout.last  = ptr == '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ita_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        count <= '0;
      end else if (ram_wr_en) begin
        count <= count + 1'b1;
      end
    end
  end

  // Hold the working value; advance it to the quotient after each digit.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      neg  <= din.signed_mode && din.value[ita_pkg::VALUE_W-1];
      base <= base_in;
      mag  <= (din.signed_mode && din.value[ita_pkg::VALUE_W-1])
              ? ita_pkg::VALUE_W'(0 - din.value) : din.value;
    end else if (state == ita_pkg::ST_WAIT && div_rsp.done) begin
      mag <= div_rsp.quotient;
    end
    if (state == ita_pkg::ST_FIN) begin
      ptr <= ita_pkg::ADDR_W'(count - 1'b1);
    end else if (state == ita_pkg::ST_OUT && out_acc && ptr != '0) begin
      ptr <= ptr - 1'b1;
    end
  end

  ita_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Digits are stored least significant first, read back in reverse.
  ita_ram #(
    .WIDTH (ita_pkg::DIGIT_W),
    .DEPTH (ita_pkg::MAX_CHARS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (count[ita_pkg::ADDR_W-1:0]),
    .wr_data (div_rsp.remainder),
    .rd_en   (ram_rd_en),
    .rd_addr (ptr),
    .rd_data (ram_rd_data)
  );

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    din.ready |-> !dout.valid)
    else $error("input ready while a character is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ita_pkg::CNT_W'(ita_pkg::MAX_CHARS))
    else $error("digit count beyond buffer");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_acc && dout.last) |=> din.ready)
    else $error("not idle after last character");

  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ita_pkg::ST_WAIT)
    else $error("divider result outside wait state");

  a_digits_first: assert property (@(posedge clk) disable iff (rst)
    (state == ita_pkg::ST_FIN) |-> count != '0)
    else $error("no digit stored at end of conversion");
`endif

endmodule
`default_nettype wire

### sim/integer_to_ascii_radix_tb.sv
// Testbench: random and directed checks of the integer to ASCII radix converter.
`default_nettype none
module integer_to_ascii_radix_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ita_pkg::*;

  // Run shaping. The tail waits TAIL_CYCLES after the last expected character
  // so a stray extra character still shows up.
  localparam int RANDOM_NUMBERS = 157;
  localparam int HOLD_CYCLES    = 700;
  localparam int TAIL_CYCLES    = 1300;
  localparam int QUIET_TAIL     = 30;

  localparam logic [CHAR_W-1:0] ZERO_CHAR     = 7'h30;
  localparam logic [CHAR_W-1:0] LETTER_A_CHAR = 7'h61;

  // One number to print, as offered on the input channel.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    logic               signed_mode;
  } print_req_t;

  // One character as it should leave the block.
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } glyph_t;

  logic clk = 1'b0;
  logic rst;

  ita_in_if  in_ch ();
  ita_out_if out_ch ();

  integer_to_ascii_radix u_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (in_ch),
    .dout (out_ch)
  );

  always #1 clk = ~clk;

  print_req_t numbers_to_print[$];
  glyph_t     expected_chars[$];

  int   total_numbers  = 0;
  int   numbers_taken  = 0;
  int   chars_checked  = 0;
  int   negatives_seen = 0;
  int   radix_clamped  = 0;
  int   errors         = 0;
  int   send_gap       = 0;
  int   recv_gap       = 0;
  logic in_fire_q      = 1'b0;
  logic hold_off;
  logic no_idle;

  // Idling runs in windows: every third block of 16 numbers is clean, and the
  // last stretch of the run has no idling on either side.
  assign no_idle = ((numbers_taken / 16) % 3 == 2) ||
                   (numbers_taken + QUIET_TAIL >= total_numbers);

  // Work out the text of one accepted number and append it to the expected
  // characters, most significant first, last mark on the final one.
  function automatic void spell_number(input print_req_t rq);
    logic [RADIX_W-1:0] base;
    logic               negative;
    logic [VALUE_W-1:0] mag;
    logic [DIGIT_W-1:0] dig;
    logic [CHAR_W-1:0]  text[$];
    glyph_t             g;
    int                 k;
    base = rq.radix;
    if (base < RADIX_MIN || base > RADIX_MAX) radix_clamped++;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;
    negative = rq.signed_mode && rq.value[VALUE_W-1];
    if (negative) negatives_seen++;
    // Magnitude wraps at 32 bits, so the most negative value stays 2^31.
    mag = negative ? (VALUE_W'(0) - rq.value) : rq.value;
    // Collect digits least significant first; drop anything past the buffer.
    do begin
      dig = DIGIT_W'(mag % VALUE_W'(base));
      if (text.size() < MAX_CHARS) begin
        text.push_back(dig < 4'd10 ? ZERO_CHAR + CHAR_W'(dig)
                                   : LETTER_A_CHAR + CHAR_W'(dig) - CHAR_W'(10));
      end
      mag = mag / VALUE_W'(base);
    end while (mag != 0);
    if (negative && text.size() < MAX_CHARS) text.push_back(MINUS_CHAR);
    for (k = text.size() - 1; k >= 0; k--) begin
      g.character = text[k];
      g.last      = (k == 0);
      expected_chars.push_back(g);
    end
  endfunction

  function automatic void queue_number(input logic [VALUE_W-1:0] v,
                                       input logic [RADIX_W-1:0] r, input logic s);
    print_req_t rq;
    rq.value       = v;
    rq.radix       = r;
    rq.signed_mode = s;
    numbers_to_print.push_back(rq);
  endfunction

  // Sample both channels at the rising edge. An accepted request is predicted
  // at once; an accepted character is checked against the oldest expectation.
  always @(posedge clk) begin
    print_req_t rq;
    glyph_t     exp_g;
    in_fire_q <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) begin
      rq.value       = in_ch.value;
      rq.radix       = in_ch.radix;
      rq.signed_mode = in_ch.signed_mode;
      spell_number(rq);
      void'(numbers_to_print.pop_front());
      numbers_taken <= numbers_taken + 1;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t ns: expected no character, got %h last %b", $time,
                 out_ch.character, out_ch.last);
        errors++;
      end else begin
        exp_g = expected_chars.pop_front();
        chars_checked++;
        if (out_ch.character !== exp_g.character) begin
          $display("%0t ns: character expected %h, got %h", $time,
                   exp_g.character, out_ch.character);
          errors++;
        end
        if (out_ch.last !== exp_g.last) begin
          $display("%0t ns: last expected %b, got %b", $time, exp_g.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  // Sender: change at the falling edge. Hold an offered request until it is
  // taken; between requests, sometimes idle in random bursts.
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap    <= 0;
    end else if (in_ch.valid && !in_fire_q) begin
      // hold: the current request has not been taken yet
    end else if (send_gap != 0) begin
      in_ch.valid <= 1'b0;
      send_gap    <= send_gap - 1;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      send_gap    <= $urandom_range(0, 12);
    end else if (numbers_to_print.size() != 0) begin
      in_ch.valid       <= 1'b1;
      in_ch.value       <= numbers_to_print[0].value;
      in_ch.radix       <= numbers_to_print[0].radix;
      in_ch.signed_mode <= numbers_to_print[0].signed_mode;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Receiver: stall in random bursts, or for the long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_gap     <= 0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (recv_gap != 0) begin
      out_ch.ready <= 1'b0;
      recv_gap     <= recv_gap - 1;
    end else if (!no_idle && $urandom_range(0, 6) == 0) begin
      out_ch.ready <= 1'b0;
      recv_gap     <= $urandom_range(0, 12);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Long receiver hold-off: the sender keeps offering, so the block backs up
  // and has to stall its input.
  initial begin
    hold_off = 1'b0;
    wait (numbers_taken >= 40);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog: far beyond the slowest legal run (every number at base 2 with
  // maximal stalls, plus the hold-off and the tail).
  initial begin
    #(3_000_000);
    $display("[integer_to_ascii_radix] ERROR");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    logic [VALUE_W-1:0] v;
    logic [RADIX_W-1:0] r;
    logic [RADIX_W-1:0] rb;
    logic               s;
    longint unsigned    p;
    int                 i;
    int                 steps;

    rst                   = 1'b1;
    in_ch.valid           = 1'b0;
    in_ch.value           = '0;
    in_ch.radix           = '0;
    in_ch.signed_mode     = 1'b0;
    out_ch.ready          = 1'b0;

    // Directed: zero, extremes of the value, the most negative value, the
    // longest text (minus plus 32 binary digits), out-of-range radixes,
    // lower-case hex and unsigned printing of values with the top bit set.
    queue_number(32'h0000_0000, 5'd10, 1'b0);
    queue_number(32'h0000_0000, 5'd2,  1'b1);
    queue_number(32'h0000_0000, 5'd16, 1'b1);
    queue_number(32'h7fff_ffff, 5'd10, 1'b1);
    queue_number(32'h8000_0000, 5'd10, 1'b1);
    queue_number(32'h8000_0000, 5'd2,  1'b1);
    queue_number(32'h8000_0000, 5'd16, 1'b0);
    queue_number(32'h8000_0000, 5'd10, 1'b0);
    queue_number(32'hffff_ffff, 5'd2,  1'b0);
    queue_number(32'hffff_ffff, 5'd10, 1'b1);
    queue_number(32'hffff_ffff, 5'd16, 1'b0);
    queue_number(32'hffff_ffff, 5'd10, 1'b0);
    queue_number(32'h0000_00ff, 5'd16, 1'b0);
    queue_number(32'h00ab_cdef, 5'd16, 1'b1);
    queue_number(32'hfff6_d2a1, 5'd16, 1'b1);
    queue_number(32'hffff_fff6, 5'd10, 1'b1);
    queue_number(32'h0000_0005, 5'd0,  1'b0);
    queue_number(32'h0000_0005, 5'd1,  1'b1);
    queue_number(32'h0000_0100, 5'd17, 1'b0);
    queue_number(32'hdead_beef, 5'd31, 1'b1);
    queue_number(32'h0000_0026, 5'd3,  1'b0);
    queue_number(32'h0000_0fff, 5'd7,  1'b1);
    queue_number(32'hffff_fc18, 5'd13, 1'b1);

    // Random: mostly mid to high radixes to keep the run short, some low
    // radixes, and a share drawn from all 32 radix codes.
    for (i = 0; i < RANDOM_NUMBERS; i++) begin
      case ($urandom_range(0, 15))
        0, 1:    r = RADIX_W'($urandom_range(0, 31));
        2, 3, 4: r = RADIX_W'($urandom_range(2, 7));
        default: r = RADIX_W'($urandom_range(8, 16));
      endcase
      rb = (r < RADIX_MIN) ? RADIX_MIN : (r > RADIX_MAX) ? RADIX_MAX : r;
      s  = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0: v = $urandom();
        1: v = $urandom_range(0, 999);
        2: v = VALUE_W'(0) - VALUE_W'($urandom_range(1, 1000));
        3: v = $urandom_range(0, 1) ? (32'h7fff_ffff - $urandom_range(0, 15))
                                    : (32'h8000_0000 + $urandom_range(0, 15));
        default: begin
          // Land on digit-count boundaries: a power of the radix or one below.
          p     = 1;
          steps = $urandom_range(0, 31);
          repeat (steps) if (p * rb < 64'h1_0000_0000) p = p * rb;
          v = VALUE_W'(p) - VALUE_W'($urandom_range(0, 1));
        end
      endcase
      queue_number(v, r, s);
    end
    total_numbers = numbers_to_print.size();

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    while (numbers_taken < total_numbers) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Printed %0d numbers as %0d characters: %0d with a minus sign,",
             numbers_taken, chars_checked, negatives_seen);
    $display("%0d with the radix clamped, one %0d-cycle output stall.",
             radix_clamped, HOLD_CYCLES);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("[integer_to_ascii_radix] OK");
    end else begin
      $display("[integer_to_ascii_radix] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
